// ----- rtl/max_flow_dfs_augment_top_defines.svh -----
// ----------------------------------------------------------------------------
// max_flow_dfs_augment_top_defines.svh
// Assertion macros shared by the max-flow checker.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_DFS_AUGMENT_TOP_DEFINES_SVH
`define MAX_FLOW_DFS_AUGMENT_TOP_DEFINES_SVH

// same-cycle implication
`define MFDFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFDFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mfdfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mfdfs_pkg
// Types and constants of the DFS max-flow engine.
// ----------------------------------------------------------------------------
package mfdfs_pkg;

  localparam int FLOW_W = 38;
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
  localparam logic [1:0] REG_SINK_NODE   = 2'd2;

  localparam logic [6:0] NODE_COUNT_RST  = 7'd64;
  localparam logic [5:0] SOURCE_NODE_RST = 6'd0;
  localparam logic [5:0] SINK_NODE_RST   = 6'd63;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic [31:0] capacity;
  } in_t;

  typedef struct packed {
    logic [FLOW_W-1:0] total_flow;
    logic              capacity_saturated;
  } out_t;

  typedef struct packed {
    logic [6:0] node_count;
    logic [5:0] source_node;
    logic [5:0] sink_node;
  } cfg_t;

endpackage

// ----- rtl/mfdfs_ram.sv -----
// ----------------------------------------------------------------------------
// mfdfs_ram
// Simple dual-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module mfdfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/mfdfs_regs.sv -----
// ----------------------------------------------------------------------------
// mfdfs_regs
// APB configuration registers: node count, source and sink.
// ----------------------------------------------------------------------------
module mfdfs_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output mfdfs_pkg::cfg_t     cfg
);

  mfdfs_pkg::cfg_t cfg_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_count  <= mfdfs_pkg::NODE_COUNT_RST;
      cfg_r.source_node <= mfdfs_pkg::SOURCE_NODE_RST;
      cfg_r.sink_node   <= mfdfs_pkg::SINK_NODE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        mfdfs_pkg::REG_NODE_COUNT:  cfg_r.node_count  <= pwdata[6:0];
        mfdfs_pkg::REG_SOURCE_NODE: cfg_r.source_node <= pwdata[5:0];
        mfdfs_pkg::REG_SINK_NODE:   cfg_r.sink_node   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mfdfs_pkg::REG_NODE_COUNT:  prdata = {25'd0, cfg_r.node_count};
      mfdfs_pkg::REG_SOURCE_NODE: prdata = {26'd0, cfg_r.source_node};
      mfdfs_pkg::REG_SINK_NODE:   prdata = {26'd0, cfg_r.sink_node};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/max_flow_dfs_augment_top.sv -----
// ----------------------------------------------------------------------------
// max_flow_dfs_augment_top
// Ford-Fulkerson max flow with depth-first augmenting searches over a
// residual capacity matrix held in RAM, with an explicit search stack.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------
//  in      | start && !busy          | in_data  (mfdfs_pkg::in_t)
//  out     | out_valid, 1-cycle      | out_data (mfdfs_pkg::out_t)
//  cfg     | APB write, pready = 1   | node_count/source/sink
//
//  Add edge: cell read in ST_IDLE, saturating write back in ST_ADD.
//  Run: neighbour probe ST_SCAN, ST_CHK (ST_SCAN only if visited), push in ST_CHK, pop ST_POP, ST_POPLD,
//  augment per path edge ST_AUGF, ST_AUGFW, ST_AUGRW, ST_AUGLD; bound by the single matrix read port.
//  After reset a clearing pass writes NODES*NODES zero cells, busy held high.
//  Results cannot be stalled; busy also covers the strobe cycle.
// ----------------------------------------------------------------------------
module max_flow_dfs_augment_top #(
  parameter int NODES     = 64,
  parameter int CAP_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mfdfs_pkg::in_t       in_data,
  output logic                 out_valid,
  output mfdfs_pkg::out_t      out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int NW    = $clog2(NODES);
  localparam int CNTW  = NW + 1;
  localparam int CELLS = NODES * NODES;
  localparam int AWD   = $clog2(CELLS);
  localparam int FRW   = NW + CNTW + CAP_WIDTH;
  localparam int SUMW  = ((CAP_WIDTH > 32) ? CAP_WIDTH : 32) + 1;
  localparam int ACCW  = ((CAP_WIDTH > mfdfs_pkg::FLOW_W) ? CAP_WIDTH : mfdfs_pkg::FLOW_W) + 1;
  localparam int CMPW  = (CNTW > 7) ? CNTW : 7;
  localparam logic [CAP_WIDTH-1:0] CAP_MAX = {CAP_WIDTH{1'b1}};

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_ADD   = 13'b0000000000100,
    ST_INIT  = 13'b0000000001000,
    ST_SCAN  = 13'b0000000010000,
    ST_CHK   = 13'b0000000100000,
    ST_POP   = 13'b0000001000000,
    ST_POPLD = 13'b0000010000000,
    ST_AUGF  = 13'b0000100000000,
    ST_AUGFW = 13'b0001000000000,
    ST_AUGRW = 13'b0010000000000,
    ST_AUGLD = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic [NW-1:0]        node;
    logic [CNTW-1:0]      next;
    logic [CAP_WIDTH-1:0] flow;
  } frame_t;

  function automatic logic [AWD-1:0] cell_addr(input logic [NW-1:0] a,
                                               input logic [NW-1:0] b);
    return AWD'(int'(a) * NODES + int'(b));
  endfunction

  mfdfs_pkg::cfg_t cfg;

  state_t                state_r, state_nxt;
  logic [AWD-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [AWD-1:0]        add_addr_r, add_addr_nxt;
  logic [31:0]           add_cap_r, add_cap_nxt;
  logic                  sat_r, sat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [mfdfs_pkg::FLOW_W-1:0] acc_r, acc_nxt;
  logic [NODES-1:0]      visited_r, visited_nxt;
  logic [NW-1:0]         top_node_r, top_node_nxt;
  logic [CNTW-1:0]       top_next_r, top_next_nxt;
  logic [CAP_WIDTH-1:0]  top_flow_r, top_flow_nxt;
  logic [NW-1:0]         tos_r, tos_nxt;
  logic [NW-1:0]         aug_a_r, aug_a_nxt;
  logic [NW-1:0]         aug_b_r, aug_b_nxt;
  logic [NW-1:0]         aug_i_r, aug_i_nxt;
  logic [CAP_WIDTH-1:0]  aug_f_r, aug_f_nxt;

  logic                  cap_we;
  logic [AWD-1:0]        cap_waddr, cap_raddr;
  logic [CAP_WIDTH-1:0]  cap_wdata, cap_rdata_r;
  logic                  stk_we;
  logic [NW-1:0]         stk_waddr, stk_raddr;
  frame_t                stk_wdata, stk_rdata_r;

  logic [CNTW-1:0]       n_eff;
  logic [NW-1:0]         src_i, snk_i, v_i;
  logic                  run_ok, add_ok, accept;
  logic [SUMW-1:0]       add_sum;
  logic [CAP_WIDTH:0]    rev_sum;
  logic [ACCW-1:0]       acc_sum;
  logic [CAP_WIDTH-1:0]  bottleneck;

  mfdfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfdfs_ram #(.WIDTH(CAP_WIDTH), .DEPTH(CELLS)) u_cap_ram (
    .clk     (clk),
    .we      (cap_we),
    .waddr   (cap_waddr),
    .wdata   (cap_wdata),
    .raddr   (cap_raddr),
    .rdata_r (cap_rdata_r)
  );

  mfdfs_ram #(.WIDTH(FRW), .DEPTH(NODES)) u_stk_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .raddr   (stk_raddr),
    .rdata_r (stk_rdata_r)
  );

  assign n_eff = (CMPW'(cfg.node_count) > CMPW'(NODES)) ? CNTW'(NODES)
                                                       : CNTW'(cfg.node_count);
  assign src_i  = NW'(cfg.source_node);
  assign snk_i  = NW'(cfg.sink_node);
  assign v_i    = top_next_r[NW-1:0];
  assign run_ok = (CMPW'(cfg.source_node) < CMPW'(n_eff)) &&
                  (CMPW'(cfg.sink_node) < CMPW'(n_eff)) &&
                  (cfg.source_node != cfg.sink_node);
  assign add_ok = (CMPW'(in_data.from_node) < CMPW'(NODES)) &&
                  (CMPW'(in_data.to_node) < CMPW'(NODES));
  assign accept = start && !busy;

  assign add_sum    = SUMW'(cap_rdata_r) + SUMW'(add_cap_r);
  assign rev_sum    = {1'b0, cap_rdata_r} + {1'b0, aug_f_r};
  assign acc_sum    = ACCW'(acc_r) + ACCW'(aug_f_r);
  assign bottleneck = (top_flow_r < cap_rdata_r) ? top_flow_r : cap_rdata_r;

  assign busy      = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data.total_flow         = acc_r;
  assign out_data.capacity_saturated = sat_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    add_addr_nxt  = add_addr_r;
    add_cap_nxt   = add_cap_r;
    sat_nxt       = sat_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    visited_nxt   = visited_r;
    top_node_nxt  = top_node_r;
    top_next_nxt  = top_next_r;
    top_flow_nxt  = top_flow_r;
    tos_nxt       = tos_r;
    aug_a_nxt     = aug_a_r;
    aug_b_nxt     = aug_b_r;
    aug_i_nxt     = aug_i_r;
    aug_f_nxt     = aug_f_r;

    cap_we    = 1'b0;
    cap_waddr = add_addr_r;
    cap_wdata = '0;
    cap_raddr = cell_addr(top_node_r, v_i);
    stk_we    = 1'b0;
    stk_waddr = tos_r;
    stk_wdata = '{node: top_node_r, next: top_next_r + CNTW'(1), flow: top_flow_r};
    stk_raddr = tos_r - NW'(1);

    unique case (state_r)
      ST_CLEAR: begin
        cap_we      = 1'b1;
        cap_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AWD'(1);
        if (clr_cnt_r == AWD'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cap_raddr = cell_addr(NW'(in_data.from_node), NW'(in_data.to_node));
        if (accept) begin
          if (in_data.cmd == mfdfs_pkg::CMD_ADD) begin
            add_addr_nxt = cap_raddr;
            add_cap_nxt  = in_data.capacity;
            if (add_ok) begin
              state_nxt = ST_ADD;
            end
          end else begin
            acc_nxt   = '0;
            state_nxt = run_ok ? ST_INIT : ST_DONE;
          end
        end
      end
      ST_ADD: begin
        cap_we = 1'b1;
        if (add_sum > SUMW'(CAP_MAX)) begin
          cap_wdata = CAP_MAX;
          sat_nxt   = 1'b1;
        end else begin
          cap_wdata = add_sum[CAP_WIDTH-1:0];
        end
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        visited_nxt        = '0;
        visited_nxt[src_i] = 1'b1;
        top_node_nxt       = src_i;
        top_next_nxt       = '0;
        top_flow_nxt       = CAP_MAX;
        tos_nxt            = '0;
        state_nxt          = ST_SCAN;
      end
      ST_SCAN: begin
        if (top_next_r >= n_eff) begin
          state_nxt = ST_POP;
        end else if (visited_r[v_i]) begin
          top_next_nxt = top_next_r + CNTW'(1);
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (cap_rdata_r == '0) begin
          top_next_nxt = top_next_r + CNTW'(1);
          state_nxt    = ST_SCAN;
        end else if (v_i == snk_i) begin
          aug_f_nxt = bottleneck;
          aug_a_nxt = top_node_r;
          aug_b_nxt = snk_i;
          aug_i_nxt = tos_r;
          state_nxt = ST_AUGF;
        end else if (tos_r == NW'(NODES - 1)) begin
          // stack full: drop this frame
          state_nxt = ST_POP;
        end else begin
          stk_we            = 1'b1;
          top_node_nxt      = v_i;
          top_next_nxt      = '0;
          top_flow_nxt      = bottleneck;
          tos_nxt           = tos_r + NW'(1);
          visited_nxt[v_i]  = 1'b1;
          state_nxt         = ST_SCAN;
        end
      end
      ST_POP: begin
        state_nxt = (tos_r == '0) ? ST_DONE : ST_POPLD;
      end
      ST_POPLD: begin
        top_node_nxt = stk_rdata_r.node;
        top_next_nxt = stk_rdata_r.next;
        top_flow_nxt = stk_rdata_r.flow;
        tos_nxt      = tos_r - NW'(1);
        state_nxt    = ST_SCAN;
      end
      ST_AUGF: begin
        cap_raddr = cell_addr(aug_a_r, aug_b_r);
        state_nxt = ST_AUGFW;
      end
      ST_AUGFW: begin
        cap_we    = 1'b1;
        cap_waddr = cell_addr(aug_a_r, aug_b_r);
        cap_wdata = cap_rdata_r - aug_f_r;
        cap_raddr = cell_addr(aug_b_r, aug_a_r);
        state_nxt = ST_AUGRW;
      end
      ST_AUGRW: begin
        cap_we    = 1'b1;
        cap_waddr = cell_addr(aug_b_r, aug_a_r);
        if (rev_sum[CAP_WIDTH]) begin
          cap_wdata = CAP_MAX;
          sat_nxt   = 1'b1;
        end else begin
          cap_wdata = rev_sum[CAP_WIDTH-1:0];
        end
        stk_raddr = aug_i_r - NW'(1);
        if (aug_i_r == '0) begin
          if (acc_sum > ACCW'(mfdfs_pkg::FLOW_MAX)) begin
            acc_nxt = mfdfs_pkg::FLOW_MAX;
          end else begin
            acc_nxt = acc_sum[mfdfs_pkg::FLOW_W-1:0];
          end
          state_nxt = ST_INIT;
        end else begin
          state_nxt = ST_AUGLD;
        end
      end
      ST_AUGLD: begin
        aug_b_nxt = aug_a_r;
        aug_a_nxt = stk_rdata_r.node;
        aug_i_nxt = aug_i_r - NW'(1);
        state_nxt = ST_AUGF;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      visited_r   <= '0;
      tos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      visited_r   <= visited_nxt;
      tos_r       <= tos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_addr_r <= add_addr_nxt;
    add_cap_r  <= add_cap_nxt;
    top_node_r <= top_node_nxt;
    top_next_r <= top_next_nxt;
    top_flow_r <= top_flow_nxt;
    aug_a_r    <= aug_a_nxt;
    aug_b_r    <= aug_b_nxt;
    aug_i_r    <= aug_i_nxt;
    aug_f_r    <= aug_f_nxt;
  end

endmodule

// ----- rtl/mfdfs_checker.sv -----
// ----------------------------------------------------------------------------
// mfdfs_checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "max_flow_dfs_augment_top_defines.svh"

module mfdfs_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input mfdfs_pkg::in_t  in_data,
  input logic            out_valid
);

  // a result strobe lasts a single cycle
  `MFDFS_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "out_valid held")
  // no request accepted while a result is on the ports
  `MFDFS_ASSERT_IMP(a_busy_on_out, clk, rst_n, out_valid, busy, "busy low with result")
  // a run request always occupies the engine
  `MFDFS_ASSERT_NXT(a_run_busy, clk, rst_n, start && !busy && in_data.cmd == mfdfs_pkg::CMD_RUN, busy, "run not busy")
  // a result only follows engine activity
  `MFDFS_ASSERT_IMP(a_out_after_work, clk, rst_n, $rose(out_valid), $past(busy), "result from idle")

endmodule

bind max_flow_dfs_augment_top mfdfs_checker u_mfdfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid)
);

// ----- tb/tb_max_flow_dfs_augment_top.sv -----
// ----------------------------------------------------------------------------
// tb_max_flow_dfs_augment_top
// Self-checking bench for the DFS max-flow engine: a directed table of edge
// loads, runs and register writes, then random graph phases; each run result is
// checked against an in-bench flow predictor or a value set in the table.
// ----------------------------------------------------------------------------
module tb_max_flow_dfs_augment_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 64;
  localparam logic [31:0] CELL_MAX = 32'hFFFF_FFFF;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  mfdfs_pkg::in_t   in_data;
  logic             out_valid;
  mfdfs_pkg::out_t  out_data;
  logic             psel, penable, pwrite;
  logic [3:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  max_flow_dfs_augment_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("FAILURE");
    $finish;
  end

  // predictor state
  logic [31:0] resid_cap [0:N*N-1];
  bit          sat_seen;
  logic [6:0]  nodes_r;
  logic [5:0]  src_r;
  logic [5:0]  snk_r;

  mfdfs_pkg::out_t flow_q[$];
  int   errors;
  int   items_sent;

  function automatic void cell_raise(int a, int b, logic [31:0] v);
    if (v > CELL_MAX - resid_cap[a*N+b]) begin
      resid_cap[a*N+b] = CELL_MAX;
      sat_seen = 1'b1;
    end else begin
      resid_cap[a*N+b] = resid_cap[a*N+b] + v;
    end
  endfunction

  // one augmenting search; returns pushed bottleneck, 0 if no path
  function automatic logic [31:0] augment_once(int n, int s, int t);
    int          stk_node [N];
    int          stk_next [N];
    logic [31:0] stk_flow [N];
    bit          seen [N];
    int          depth, top, u, v;
    logic [31:0] f;
    for (int k = 0; k < N; k++) seen[k] = 1'b0;
    seen[s] = 1'b1;
    stk_node[0] = s;
    stk_next[0] = 0;
    stk_flow[0] = CELL_MAX;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      u = stk_node[top];
      v = stk_next[top];
      while (v < n && (resid_cap[u*N+v] == 0 || seen[v])) v++;
      if (v >= n) begin
        depth--;
        continue;
      end
      stk_next[top] = v + 1;
      f = resid_cap[u*N+v];
      if (stk_flow[top] < f) f = stk_flow[top];
      if (v == t) begin
        for (int i = 0; i <= top; i++) begin
          int a, b;
          a = stk_node[i];
          b = (i == top) ? t : stk_node[i+1];
          resid_cap[a*N+b] = resid_cap[a*N+b] - f;
          cell_raise(b, a, f);
        end
        return f;
      end
      if (depth >= N) begin
        depth--;
        continue;
      end
      seen[v] = 1'b1;
      stk_node[depth] = v;
      stk_next[depth] = 0;
      stk_flow[depth] = f;
      depth++;
    end
    return 32'd0;
  endfunction

  function automatic mfdfs_pkg::out_t max_flow_run();
    mfdfs_pkg::out_t r;
    logic [63:0]     acc, f;
    int              n;
    n = (nodes_r > N) ? N : int'(nodes_r);
    acc = 64'd0;
    if (src_r < n && snk_r < n && src_r != snk_r) begin
      forever begin
        f = 64'(augment_once(n, src_r, snk_r));
        if (f == 0) break;
        if (f > 64'(mfdfs_pkg::FLOW_MAX) - acc) acc = 64'(mfdfs_pkg::FLOW_MAX);
        else acc = acc + f;
      end
    end
    r.total_flow = acc[mfdfs_pkg::FLOW_W-1:0];
    r.capacity_saturated = sat_seen;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (flow_q.size() == 0) begin
        $error("unexpected result: total_flow %0d", out_data.total_flow);
        errors++;
      end else begin
        mfdfs_pkg::out_t w;
        w = flow_q.pop_front();
        if (out_data.total_flow !== w.total_flow) begin
          $error("total_flow expected %0d actual %0d", w.total_flow, out_data.total_flow);
          errors++;
        end
        if (out_data.capacity_saturated !== w.capacity_saturated) begin
          $error("capacity_saturated expected %0b actual %0b",
                 w.capacity_saturated, out_data.capacity_saturated);
          errors++;
        end
      end
    end
  end

  task automatic send_request(mfdfs_pkg::in_t x, bit typed, mfdfs_pkg::out_t want);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    items_sent++;
    if (x.cmd == mfdfs_pkg::CMD_RUN) begin
      mfdfs_pkg::out_t p;
      p = max_flow_run();
      flow_q.push_back(typed ? want : p);
    end else begin
      cell_raise(x.from_node, x.to_node, x.capacity);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (flow_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      mfdfs_pkg::REG_NODE_COUNT:  nodes_r = val[6:0];
      mfdfs_pkg::REG_SOURCE_NODE: src_r = val[5:0];
      mfdfs_pkg::REG_SINK_NODE:   snk_r = val[5:0];
      default: ;
    endcase
  endtask

  typedef struct {
    bit              is_reg;
    logic [1:0]      idx;
    logic [31:0]     val;
    mfdfs_pkg::in_t  item;
    bit              typed;
    mfdfs_pkg::out_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void plan_reg(logic [1:0] idx, logic [31:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endfunction

  function automatic void plan_add(int a, int b, logic [31:0] c);
    plan_row_t r;
    r = '{default: '0};
    r.item = '{cmd: mfdfs_pkg::CMD_ADD, from_node: a[5:0], to_node: b[5:0], capacity: c};
    plan.push_back(r);
  endfunction

  function automatic void plan_run(bit typed, logic [mfdfs_pkg::FLOW_W-1:0] fl, bit sat);
    plan_row_t r;
    r = '{default: '0};
    r.item = '{cmd: mfdfs_pkg::CMD_RUN, from_node: '1, to_node: '1, capacity: '1};
    r.typed = typed;
    r.want = '{total_flow: fl, capacity_saturated: sat};
    plan.push_back(r);
  endfunction

  function automatic logic [31:0] rand_cap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, 255);
    if (p < 90) return $urandom;
    return $urandom | 32'hFFFF_0000;
  endfunction

  initial begin
    int n_eff;
    errors = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int k = 0; k < N*N; k++) resid_cap[k] = '0;
    sat_seen = 1'b0;
    nodes_r = mfdfs_pkg::NODE_COUNT_RST;
    src_r = mfdfs_pkg::SOURCE_NODE_RST;
    snk_r = mfdfs_pkg::SINK_NODE_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    plan_run(1, 0, 0);                     // empty graph after reset
    plan_add(0, 63, CELL_MAX);
    plan_run(1, 38'h00FFFFFFFF, 0);
    plan_add(0, 63, CELL_MAX);
    plan_add(0, 63, 1);                    // cell overflow on add
    plan_run(1, 38'h00FFFFFFFF, 1);        // reverse cell saturates too
    plan_reg(mfdfs_pkg::REG_SINK_NODE, 0);            // source equals sink
    plan_run(1, 0, 1);
    plan_reg(mfdfs_pkg::REG_NODE_COUNT, 2);
    plan_reg(mfdfs_pkg::REG_SINK_NODE, 63);           // sink outside node count
    plan_run(1, 0, 1);
    plan_reg(mfdfs_pkg::REG_NODE_COUNT, 127);         // clamps to full size
    plan_reg(mfdfs_pkg::REG_SOURCE_NODE, 63);
    plan_reg(mfdfs_pkg::REG_SINK_NODE, 5);
    plan_add(63, 5, 7);
    plan_add(5, 63, 0);
    plan_run(0, 0, 0);
    plan_reg(mfdfs_pkg::REG_NODE_COUNT, 64);
    plan_reg(mfdfs_pkg::REG_SOURCE_NODE, 1);
    plan_reg(mfdfs_pkg::REG_SINK_NODE, 4);
    plan_add(1, 2, 5);
    plan_add(2, 4, 3);
    plan_add(1, 3, 4);
    plan_add(3, 2, 6);
    plan_add(3, 4, 2);
    plan_run(0, 0, 0);
    plan_run(0, 0, 0);                     // residual kept: nothing left

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_idle();
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_request(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // random graph phases
    while (items_sent < 1100) begin
      int p, cnt;
      logic [31:0] nc;
      wait_idle();
      p = $urandom_range(0, 99);
      if (p < 70) nc = $urandom_range(2, 10);
      else if (p < 85) nc = 64;
      else if (p < 95) nc = $urandom_range(65, 127);
      else nc = $urandom_range(0, 1);
      nc = nc | ($urandom & 32'hFFFF_FF80);   // upper bits ignored
      reg_write(mfdfs_pkg::REG_NODE_COUNT, nc);
      n_eff = (nc[6:0] > N) ? N : ((nc[6:0] < 2) ? 2 : int'(nc[6:0]));
      if ($urandom_range(0, 9) == 0) reg_write(mfdfs_pkg::REG_SOURCE_NODE, $urandom);
      else reg_write(mfdfs_pkg::REG_SOURCE_NODE,
                     $urandom_range(0, n_eff - 1) | ($urandom & ~32'h3F));
      if ($urandom_range(0, 9) == 0) reg_write(mfdfs_pkg::REG_SINK_NODE, $urandom);
      else reg_write(mfdfs_pkg::REG_SINK_NODE, $urandom_range(0, n_eff - 1));
      cnt = $urandom_range(3, 30);
      for (int k = 0; k < cnt; k++) begin
        mfdfs_pkg::in_t  x;
        mfdfs_pkg::out_t none;
        none = '0;
        x.cmd = mfdfs_pkg::CMD_ADD;
        if ($urandom_range(0, 4) == 0) begin
          x.from_node = $urandom;
          x.to_node = $urandom;
        end else begin
          x.from_node = $urandom_range(0, n_eff - 1);
          x.to_node = $urandom_range(0, n_eff - 1);
        end
        x.capacity = rand_cap();
        if ($urandom_range(0, 19) == 0) x.cmd = mfdfs_pkg::CMD_RUN;   // run mid-load
        send_request(x, 1'b0, none);
      end
      begin
        mfdfs_pkg::in_t  x;
        mfdfs_pkg::out_t none;
        none = '0;
        x = $urandom;
        x.capacity = $urandom;
        x.cmd = mfdfs_pkg::CMD_RUN;
        send_request(x, 1'b0, none);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (flow_q.size() != 0) begin
      $error("%0d results never arrived", flow_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
